/* rtl/core/wrcp_pkg.sv */
`timescale 1ns / 1ps

package wrcp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int unsigned FMT_LEN = 16;
    localparam logic [4:0]  FMT_LEN_IDX = 5'(FMT_LEN);
    localparam logic [31:0] FMT_LEN_W   = 32'(FMT_LEN);
    localparam logic [4:0]  TAG_LEN_IDX = 5'd4;

    typedef enum logic [3:0] {
        PH_RIFF_TAG   = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE_TAG   = 4'd2,
        PH_CHUNK_ID   = 4'd3,
        PH_CHUNK_SIZE = 4'd4,
        PH_FMT_BODY   = 4'd5,
        PH_SKIP       = 4'd6,
        PH_PAD        = 4'd7,
        PH_DATA       = 4'd8,
        PH_AFTER_OK   = 4'd9,
        PH_ERR_RIFF   = 4'd10,
        PH_ERR_WAVE   = 4'd11,
        PH_ERR_FMT    = 4'd12,
        PH_ERR_EMPTY  = 4'd13
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_RIFF   = 3'd1,
        ST_NO_WAVE   = 3'd2,
        ST_NO_FMT    = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_TRUNCATED = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  audio_byte;
        logic        done_res;
        t_status     status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
    } t_result;

    // Status reported at end of file, taken from the phase after the final byte.
    function automatic t_status end_status(input t_phase phase, input logic fmt_seen);
        t_status st;
        unique case (phase)
            PH_RIFF_TAG, PH_ERR_RIFF:              st = ST_NO_RIFF;
            PH_RIFF_SIZE, PH_WAVE_TAG, PH_ERR_WAVE: st = ST_NO_WAVE;
            PH_ERR_FMT:                            st = ST_NO_FMT;
            PH_ERR_EMPTY:                          st = ST_EMPTY;
            PH_DATA:                               st = ST_TRUNCATED;
            PH_AFTER_OK:                           st = ST_OK;
            default:                               st = fmt_seen ? ST_NO_DATA : ST_NO_FMT;
        endcase
        return st;
    endfunction

endpackage

/* rtl/core/wrcp_in_reg.sv */
`timescale 1ns / 1ps

module wrcp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  wrcp_pkg::t_in_item i_item,
    input  logic               i_take,
    output logic               o_valid,
    output wrcp_pkg::t_in_item o_item
);

    logic               r_valid;
    wrcp_pkg::t_in_item r_item;
    logic               w_accept;

    // The register can be refilled in the same cycle its request moves on.
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/wrcp_step.sv */
`timescale 1ns / 1ps

module wrcp_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  wrcp_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output wrcp_pkg::t_result  o_res
);

    wrcp_pkg::t_phase  r_phase, n_phase;
    logic [4:0]        r_idx, n_idx;
    logic [31:0]       r_tag, n_tag;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_rem, n_rem;
    logic [15:0][7:0]  r_fmt, n_fmt;
    logic              r_seen, n_seen;

    logic [4:0]        w_idx_inc;
    logic [31:0]       w_tag_next;
    logic [31:0]       w_size_next;
    logic [31:0]       w_rem_dec;
    logic [31:0]       w_fmt_extra;
    logic              w_emit;
    logic [7:0]        w_byte;

    assign w_byte      = i_item.file_byte;
    assign w_idx_inc   = r_idx + 5'd1;
    assign w_tag_next  = {r_tag[23:0], w_byte};
    assign w_size_next = {w_byte, r_size[31:8]};
    assign w_rem_dec   = r_rem - 32'd1;
    assign w_fmt_extra = (r_size > wrcp_pkg::FMT_LEN_W) ? r_size - wrcp_pkg::FMT_LEN_W : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wrcp_pkg::PH_RIFF_TAG;
            r_idx   <= '0;
            r_tag   <= '0;
            r_size  <= '0;
            r_rem   <= '0;
            r_fmt   <= '0;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            if (i_item.end_of_file) begin
                // The final byte of a file returns the parser to its reset state.
                r_phase <= wrcp_pkg::PH_RIFF_TAG;
                r_idx   <= '0;
                r_tag   <= '0;
                r_size  <= '0;
                r_rem   <= '0;
                r_fmt   <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_tag   <= n_tag;
                r_size  <= n_size;
                r_rem   <= n_rem;
                r_fmt   <= n_fmt;
                r_seen  <= n_seen;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_tag   = r_tag;
        n_size  = r_size;
        n_rem   = r_rem;
        n_fmt   = r_fmt;
        n_seen  = r_seen;
        w_emit  = 1'b0;

        unique case (r_phase)
            wrcp_pkg::PH_RIFF_TAG, wrcp_pkg::PH_WAVE_TAG, wrcp_pkg::PH_CHUNK_ID: begin
                n_tag = w_tag_next;
                n_idx = w_idx_inc;
                if (w_idx_inc >= wrcp_pkg::TAG_LEN_IDX) begin
                    n_idx = '0;
                    if (r_phase == wrcp_pkg::PH_RIFF_TAG) begin
                        n_phase = (w_tag_next == wrcp_pkg::TAG_RIFF) ?
                                  wrcp_pkg::PH_RIFF_SIZE : wrcp_pkg::PH_ERR_RIFF;
                    end else if (r_phase == wrcp_pkg::PH_WAVE_TAG) begin
                        n_phase = (w_tag_next == wrcp_pkg::TAG_WAVE) ?
                                  wrcp_pkg::PH_CHUNK_ID : wrcp_pkg::PH_ERR_WAVE;
                    end else begin
                        n_phase = wrcp_pkg::PH_CHUNK_SIZE;
                    end
                end
            end
            wrcp_pkg::PH_RIFF_SIZE, wrcp_pkg::PH_CHUNK_SIZE: begin
                n_size = w_size_next;
                n_idx  = w_idx_inc;
                if (w_idx_inc >= wrcp_pkg::TAG_LEN_IDX) begin
                    n_idx = '0;
                    if (r_phase == wrcp_pkg::PH_RIFF_SIZE) begin
                        n_phase = wrcp_pkg::PH_WAVE_TAG;
                    end else if (r_tag == wrcp_pkg::TAG_FMT) begin
                        n_seen  = 1'b1;
                        n_phase = wrcp_pkg::PH_FMT_BODY;
                    end else if (r_tag == wrcp_pkg::TAG_DATA) begin
                        if (!r_seen) begin
                            n_phase = wrcp_pkg::PH_ERR_FMT;
                        end else if (w_size_next == 32'd0) begin
                            n_phase = wrcp_pkg::PH_ERR_EMPTY;
                        end else begin
                            n_rem   = w_size_next;
                            n_phase = wrcp_pkg::PH_DATA;
                        end
                    end else if (w_size_next != 32'd0) begin
                        n_rem   = w_size_next;
                        n_phase = wrcp_pkg::PH_SKIP;
                    end else begin
                        n_phase = w_size_next[0] ? wrcp_pkg::PH_PAD : wrcp_pkg::PH_CHUNK_ID;
                    end
                end
            end
            wrcp_pkg::PH_FMT_BODY: begin
                n_fmt[r_idx[3:0]] = w_byte;
                n_idx = w_idx_inc;
                if (w_idx_inc >= wrcp_pkg::FMT_LEN_IDX) begin
                    // Short fmt chunks still capture all sixteen bytes.
                    if (w_fmt_extra != 32'd0) begin
                        n_rem   = w_fmt_extra;
                        n_phase = wrcp_pkg::PH_SKIP;
                    end else begin
                        n_idx   = '0;
                        n_phase = r_size[0] ? wrcp_pkg::PH_PAD : wrcp_pkg::PH_CHUNK_ID;
                    end
                end
            end
            wrcp_pkg::PH_SKIP: begin
                n_rem = w_rem_dec;
                if (w_rem_dec == 32'd0) begin
                    n_idx   = '0;
                    n_phase = r_size[0] ? wrcp_pkg::PH_PAD : wrcp_pkg::PH_CHUNK_ID;
                end
            end
            wrcp_pkg::PH_PAD: begin
                n_idx   = '0;
                n_phase = wrcp_pkg::PH_CHUNK_ID;
            end
            wrcp_pkg::PH_DATA: begin
                w_emit = 1'b1;
                n_rem  = w_rem_dec;
                if (w_rem_dec == 32'd0) begin
                    n_phase = wrcp_pkg::PH_AFTER_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        o_res.has_byte = w_emit;
        if (w_emit) begin
            o_res.audio_byte = w_byte;
        end
        if (i_item.end_of_file) begin
            // The end result sees the state as it stands after this byte.
            o_res.done_res      = 1'b1;
            o_res.status        = wrcp_pkg::end_status(n_phase, n_seen);
            o_res.format_tag    = {n_fmt[1], n_fmt[0]};
            o_res.channel_count = {n_fmt[3], n_fmt[2]};
            o_res.sample_rate   = {n_fmt[7], n_fmt[6], n_fmt[5], n_fmt[4]};
            o_res.byte_rate     = {n_fmt[11], n_fmt[10], n_fmt[9], n_fmt[8]};
            o_res.block_align   = {n_fmt[13], n_fmt[12]};
            o_res.sample_bits   = {n_fmt[15], n_fmt[14]};
        end
    end

    assign o_res_valid = w_emit || i_item.end_of_file;

endmodule

/* rtl/core/wrcp_out_reg.sv */
`timescale 1ns / 1ps

module wrcp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wrcp_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output wrcp_pkg::t_result o_res
);

    logic              r_valid;
    wrcp_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/core/wav_riff_chunk_parser_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_file_byte, i_end_of_file
// result    out        o_out_valid / i_out_stall o_has_byte ... o_sample_bits
//
// One file byte per clock while no stall holds it. A byte waits in the input
// register, and its result (if any) is loaded into the result register as the byte leaves it.
// The chunk walk is one state update per byte; the 32-bit remaining-count
// decrement and compare set the longest path.
// Reset is synchronous, active low; end of file also returns the parser to reset.
// A stalled result holds the pipeline: input stall rises only when both stages are full.

module wav_riff_chunk_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_byte,
    output logic [7:0]  o_audio_byte,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [15:0] o_format_tag,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_block_align,
    output logic [15:0] o_sample_bits
);

    wrcp_pkg::t_in_item w_in_item;
    wrcp_pkg::t_in_item w_cur_item;
    wrcp_pkg::t_result  w_step_res;
    wrcp_pkg::t_result  w_out_res;
    logic               w_cur_valid;
    logic               w_out_free;
    logic               w_step;
    logic               w_res_valid;

    assign w_in_item.file_byte   = i_file_byte;
    assign w_in_item.end_of_file = i_end_of_file;

    // A byte advances only when the result register can take whatever it yields.
    assign w_step = w_cur_valid && w_out_free;

    wrcp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_take  (w_step),
        .o_valid (w_cur_valid),
        .o_item  (w_cur_item)
    );

    wrcp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (w_cur_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_step_res)
    );

    wrcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_res_valid),
        .i_res   (w_step_res),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_has_byte      = w_out_res.has_byte;
    assign o_audio_byte    = w_out_res.audio_byte;
    assign o_done_res      = w_out_res.done_res;
    assign o_status        = w_out_res.status;
    assign o_format_tag    = w_out_res.format_tag;
    assign o_channel_count = w_out_res.channel_count;
    assign o_sample_rate   = w_out_res.sample_rate;
    assign o_byte_rate     = w_out_res.byte_rate;
    assign o_block_align   = w_out_res.block_align;
    assign o_sample_bits   = w_out_res.sample_bits;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int RANDOM_BYTES = 380;
    localparam int TAIL_BYTES   = 150;
    localparam int DRAIN_GUARD  = 5000;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} t_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_file_byte;
    logic        i_end_of_file;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_has_byte;
    logic [7:0]  o_audio_byte;
    logic        o_done_res;
    logic [2:0]  o_status;
    logic [15:0] o_format_tag;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [31:0] o_byte_rate;
    logic [15:0] o_block_align;
    logic [15:0] o_sample_bits;

    wav_riff_chunk_parser_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_file_byte     (i_file_byte),
        .i_end_of_file   (i_end_of_file),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_has_byte      (o_has_byte),
        .o_audio_byte    (o_audio_byte),
        .o_done_res      (o_done_res),
        .o_status        (o_status),
        .o_format_tag    (o_format_tag),
        .o_channel_count (o_channel_count),
        .o_sample_rate   (o_sample_rate),
        .o_byte_rate     (o_byte_rate),
        .o_block_align   (o_block_align),
        .o_sample_bits   (o_sample_bits)
    );

    // Parser state as the testbench tracks it.
    wrcp_pkg::t_phase phase;
    logic [4:0]       byte_idx;
    logic [31:0]      tag_acc;
    logic [31:0]      size_acc;
    logic [31:0]      left_cnt;
    logic [7:0]       fmt_mem [16];
    logic             fmt_hdr_seen;

    wrcp_pkg::t_result expected_results [$];
    logic [7:0]  file_q [$];
    int          err_cnt;
    int          cycle_cnt;
    int          bytes_sent;
    bit          in_gaps;
    bit          out_gaps;
    bit          hold_req;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("wav_riff_chunk_parser_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < 100) begin
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        err_cnt++;
    endtask

    function automatic void clear_parser();
        phase        = wrcp_pkg::PH_RIFF_TAG;
        byte_idx     = '0;
        tag_acc      = '0;
        size_acc     = '0;
        left_cnt     = '0;
        fmt_mem      = '{default: 8'h00};
        fmt_hdr_seen = 1'b0;
    endfunction

    // A pad byte follows any skipped or fmt chunk body of odd size.
    function automatic void end_of_body();
        byte_idx = '0;
        phase    = size_acc[0] ? wrcp_pkg::PH_PAD : wrcp_pkg::PH_CHUNK_ID;
    endfunction

    function automatic void skip_bytes(input logic [31:0] n);
        if (n != 0) begin
            left_cnt = n;
            phase    = wrcp_pkg::PH_SKIP;
        end else begin
            end_of_body();
        end
    endfunction

    function automatic wrcp_pkg::t_status file_status();
        case (phase)
            wrcp_pkg::PH_RIFF_TAG, wrcp_pkg::PH_ERR_RIFF:
                return wrcp_pkg::ST_NO_RIFF;
            wrcp_pkg::PH_RIFF_SIZE, wrcp_pkg::PH_WAVE_TAG, wrcp_pkg::PH_ERR_WAVE:
                return wrcp_pkg::ST_NO_WAVE;
            wrcp_pkg::PH_ERR_FMT:   return wrcp_pkg::ST_NO_FMT;
            wrcp_pkg::PH_ERR_EMPTY: return wrcp_pkg::ST_EMPTY;
            wrcp_pkg::PH_DATA:      return wrcp_pkg::ST_TRUNCATED;
            wrcp_pkg::PH_AFTER_OK:  return wrcp_pkg::ST_OK;
            default: return fmt_hdr_seen ? wrcp_pkg::ST_NO_DATA : wrcp_pkg::ST_NO_FMT;
        endcase
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eof);
        wrcp_pkg::t_result r;
        logic              emit;
        emit = 1'b0;
        case (phase)
            wrcp_pkg::PH_RIFF_TAG, wrcp_pkg::PH_WAVE_TAG, wrcp_pkg::PH_CHUNK_ID: begin
                tag_acc  = {tag_acc[23:0], b};
                byte_idx = byte_idx + 5'd1;
                if (byte_idx >= wrcp_pkg::TAG_LEN_IDX) begin
                    byte_idx = '0;
                    if (phase == wrcp_pkg::PH_RIFF_TAG) begin
                        phase = (tag_acc == wrcp_pkg::TAG_RIFF) ?
                                wrcp_pkg::PH_RIFF_SIZE : wrcp_pkg::PH_ERR_RIFF;
                    end else if (phase == wrcp_pkg::PH_WAVE_TAG) begin
                        phase = (tag_acc == wrcp_pkg::TAG_WAVE) ?
                                wrcp_pkg::PH_CHUNK_ID : wrcp_pkg::PH_ERR_WAVE;
                    end else begin
                        phase = wrcp_pkg::PH_CHUNK_SIZE;
                    end
                end
            end
            wrcp_pkg::PH_RIFF_SIZE, wrcp_pkg::PH_CHUNK_SIZE: begin
                size_acc = {b, size_acc[31:8]};
                byte_idx = byte_idx + 5'd1;
                if (byte_idx >= wrcp_pkg::TAG_LEN_IDX) begin
                    byte_idx = '0;
                    if (phase == wrcp_pkg::PH_RIFF_SIZE) begin
                        phase = wrcp_pkg::PH_WAVE_TAG;
                    end else if (tag_acc == wrcp_pkg::TAG_FMT) begin
                        fmt_hdr_seen = 1'b1;
                        phase        = wrcp_pkg::PH_FMT_BODY;
                    end else if (tag_acc == wrcp_pkg::TAG_DATA) begin
                        if (!fmt_hdr_seen) begin
                            phase = wrcp_pkg::PH_ERR_FMT;
                        end else if (size_acc == 32'd0) begin
                            phase = wrcp_pkg::PH_ERR_EMPTY;
                        end else begin
                            left_cnt = size_acc;
                            phase    = wrcp_pkg::PH_DATA;
                        end
                    end else begin
                        skip_bytes(size_acc);
                    end
                end
            end
            wrcp_pkg::PH_FMT_BODY: begin
                // Sixteen bytes are always captured, whatever the chunk size says.
                fmt_mem[byte_idx[3:0]] = b;
                byte_idx = byte_idx + 5'd1;
                if (byte_idx >= wrcp_pkg::FMT_LEN_IDX) begin
                    skip_bytes(size_acc > wrcp_pkg::FMT_LEN_W ?
                               size_acc - wrcp_pkg::FMT_LEN_W : 32'd0);
                end
            end
            wrcp_pkg::PH_SKIP: begin
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0) end_of_body();
            end
            wrcp_pkg::PH_PAD: begin
                byte_idx = '0;
                phase    = wrcp_pkg::PH_CHUNK_ID;
            end
            wrcp_pkg::PH_DATA: begin
                emit     = 1'b1;
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0) phase = wrcp_pkg::PH_AFTER_OK;
            end
            default: begin
            end
        endcase

        if (emit || eof) begin
            r = '0;
            if (emit) begin
                r.has_byte   = 1'b1;
                r.audio_byte = b;
            end
            if (eof) begin
                r.done_res      = 1'b1;
                r.status        = file_status();
                r.format_tag    = {fmt_mem[1], fmt_mem[0]};
                r.channel_count = {fmt_mem[3], fmt_mem[2]};
                r.sample_rate   = {fmt_mem[7], fmt_mem[6], fmt_mem[5], fmt_mem[4]};
                r.byte_rate     = {fmt_mem[11], fmt_mem[10], fmt_mem[9], fmt_mem[8]};
                r.block_align   = {fmt_mem[13], fmt_mem[12]};
                r.sample_bits   = {fmt_mem[15], fmt_mem[14]};
                clear_parser();
            end
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        wrcp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(o_audio_byte), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_has_byte !== want.has_byte)
                    report_mismatch("has_byte", 32'(o_has_byte), 32'(want.has_byte));
                if (o_audio_byte !== want.audio_byte)
                    report_mismatch("audio_byte", 32'(o_audio_byte), 32'(want.audio_byte));
                if (o_done_res !== want.done_res)
                    report_mismatch("done_res", 32'(o_done_res), 32'(want.done_res));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_format_tag !== want.format_tag)
                    report_mismatch("format_tag", 32'(o_format_tag), 32'(want.format_tag));
                if (o_channel_count !== want.channel_count)
                    report_mismatch("channel_count", 32'(o_channel_count),
                                    32'(want.channel_count));
                if (o_sample_rate !== want.sample_rate)
                    report_mismatch("sample_rate", o_sample_rate, want.sample_rate);
                if (o_byte_rate !== want.byte_rate)
                    report_mismatch("byte_rate", o_byte_rate, want.byte_rate);
                if (o_block_align !== want.block_align)
                    report_mismatch("block_align", 32'(o_block_align),
                                    32'(want.block_align));
                if (o_sample_bits !== want.sample_bits)
                    report_mismatch("sample_bits", 32'(o_sample_bits),
                                    32'(want.sample_bits));
            end
        end
    end

    // Result side: random stall bursts, or one long hold when asked for.
    initial begin : out_stall_driver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (out_gaps && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_file_byte   = b;
        i_end_of_file = eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(b, eof);
        bytes_sent++;
    endtask

    // Sends the buffered file, cut short after the given number of bytes if nonzero.
    task automatic send_file(input int cut);
        int n;
        n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (int k = 0; k < n; k++) send_byte(file_q[k], k == n - 1);
    endtask

    task automatic wait_all_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            report_mismatch("results never arrived", 32'(expected_results.size()), 32'd0);
            expected_results.delete();
        end
    endtask

    function automatic void put_tag(input logic [31:0] id);
        file_q.push_back(id[31:24]);
        file_q.push_back(id[23:16]);
        file_q.push_back(id[15:8]);
        file_q.push_back(id[7:0]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[31:24]);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_chunk(input logic [31:0] id, input logic [31:0] len,
                                      input int body);
        put_tag(id);
        put_le32(len);
        put_random(body);
        if (len[0] && 32'(body) == len) put_random(1);
    endfunction

    function automatic void put_fmt(input int len, input t_fill fill);
        put_tag(wrcp_pkg::TAG_FMT);
        put_le32(32'(len));
        for (int k = 0; k < (len > 16 ? len : 16); k++) begin
            case (fill)
                FILL_ZERO: file_q.push_back(8'h00);
                FILL_ONES: file_q.push_back(8'hFF);
                default:   file_q.push_back(8'($urandom));
            endcase
        end
        if (len % 2 == 1) put_random(1);
    endfunction

    function automatic void start_wave();
        file_q.delete();
        put_tag(wrcp_pkg::TAG_RIFF);
        put_le32($urandom);
        put_tag(wrcp_pkg::TAG_WAVE);
    endfunction

    // Now and then a tag gets one bit flipped.
    function automatic logic [31:0] mangle(input logic [31:0] id);
        return ($urandom_range(0, 19) == 0) ? id ^ (32'h1 << $urandom_range(0, 31)) : id;
    endfunction

    function automatic void build_random_file();
        int          len;
        logic [31:0] id;
        file_q.delete();
        put_tag(mangle(wrcp_pkg::TAG_RIFF));
        put_le32($urandom);
        put_tag(mangle(wrcp_pkg::TAG_WAVE));
        repeat ($urandom_range(0, 2)) begin
            len = $urandom_range(0, 9);
            put_chunk($urandom, 32'(len), len);
        end
        if ($urandom_range(0, 9) != 0) put_fmt($urandom_range(12, 22), FILL_RANDOM);
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(0, 9);
            put_chunk($urandom, 32'(len), len);
        end
        if ($urandom_range(0, 5) == 0) put_fmt($urandom_range(14, 19), FILL_RANDOM);
        if ($urandom_range(0, 15) == 0) begin
            // Oversized chunk: the file ends long before its body would.
            case ($urandom_range(0, 2))
                0:       id = wrcp_pkg::TAG_DATA;
                1:       id = wrcp_pkg::TAG_FMT;
                default: id = $urandom;
            endcase
            put_chunk(id, $urandom | 32'h8000_0000, $urandom_range(0, 20));
            return;
        end
        len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
        put_chunk(mangle(wrcp_pkg::TAG_DATA), 32'(len), len);
        put_random($urandom_range(0, 6));
    endfunction

    task automatic test_header_errors();
        // End of file inside the RIFF tag.
        file_q = {8'h52};
        send_file(0);
        file_q.delete();
        put_tag(wrcp_pkg::TAG_RIFF ^ 32'h1);
        put_random(3);
        send_file(0);
        // End of file inside the RIFF size.
        file_q.delete();
        put_tag(wrcp_pkg::TAG_RIFF);
        put_le32(32'hFFFF_FFFF);
        send_file(6);
        file_q.delete();
        put_tag(wrcp_pkg::TAG_RIFF);
        put_le32(32'h0);
        put_tag(wrcp_pkg::TAG_WAVE ^ 32'h100);
        put_random(2);
        send_file(0);
        // End of file inside the WAVE tag.
        start_wave();
        send_file(10);
    endtask

    task automatic test_chunk_errors();
        start_wave();
        send_file(0);
        start_wave();
        put_chunk(wrcp_pkg::TAG_DATA, 32'd4, 4);
        send_file(0);
        // End of file while the extra fmt bytes are being skipped.
        start_wave();
        put_fmt(20, FILL_RANDOM);
        send_file(file_q.size() - 2);
        start_wave();
        put_fmt(16, FILL_RANDOM);
        put_chunk($urandom, 32'd3, 3);
        send_file(0);
        start_wave();
        put_fmt(16, FILL_RANDOM);
        put_chunk(wrcp_pkg::TAG_DATA, 32'd0, 0);
        put_random(3);
        send_file(0);
        start_wave();
        put_fmt(16, FILL_RANDOM);
        put_chunk(wrcp_pkg::TAG_DATA, 32'd8, 5);
        send_file(0);
        start_wave();
        put_fmt(16, FILL_RANDOM);
        put_chunk(wrcp_pkg::TAG_DATA, 32'hFFFF_FFFF, 3);
        send_file(0);
    endtask

    task automatic test_good_files();
        // The last data byte carries the end of file, so both share one result.
        start_wave();
        put_fmt(16, FILL_ONES);
        put_tag(wrcp_pkg::TAG_DATA);
        put_le32(32'd1);
        file_q.push_back(8'h00);
        send_file(0);
        start_wave();
        put_fmt(16, FILL_ZERO);
        put_tag(wrcp_pkg::TAG_DATA);
        put_le32(32'd2);
        file_q.push_back(8'hFF);
        file_q.push_back(8'hFF);
        put_random(4);
        send_file(0);
        // Short fmt, odd and empty unknown chunks, then a second fmt that overrides.
        start_wave();
        put_fmt(3, FILL_RANDOM);
        put_chunk($urandom, 32'd5, 5);
        put_chunk($urandom, 32'd0, 0);
        put_fmt(17, FILL_RANDOM);
        put_chunk(wrcp_pkg::TAG_DATA, 32'd3, 3);
        send_file(0);
    endtask

    task automatic test_backpressure();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        start_wave();
        put_fmt(16, FILL_RANDOM);
        put_chunk(wrcp_pkg::TAG_DATA, 32'd40, 40);
        hold_req = 1'b1;
        send_file(0);
        wait_all_results();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
    endtask

    task automatic test_random_files(input int budget);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            if ($urandom_range(0, 7) == 0) begin
                file_q.delete();
                put_random($urandom_range(1, 40));
            end else begin
                build_random_file();
            end
            send_file($urandom_range(0, 3) == 0 ? $urandom_range(1, file_q.size()) : 0);
        end
    endtask

    task automatic test_quiet_tail();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        test_random_files(TAIL_BYTES);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_file_byte   = 8'h00;
        i_end_of_file = 1'b0;
        in_gaps       = 1'b1;
        out_gaps      = 1'b1;
        clear_parser();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_errors();
        wait_all_results();
        test_chunk_errors();
        wait_all_results();
        test_good_files();
        wait_all_results();
        test_backpressure();
        test_random_files(RANDOM_BYTES);
        wait_all_results();
        test_quiet_tail();
        wait_all_results();
        repeat (10) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("wav_riff_chunk_parser_core verification clean");
        end else begin
            $display("wav_riff_chunk_parser_core verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/wrcp_pkg.sv
rtl/core/wrcp_in_reg.sv
rtl/core/wrcp_step.sv
rtl/core/wrcp_out_reg.sv
rtl/core/wav_riff_chunk_parser_core.sv
dv/tb_top.sv
